// ----- design/dq_pkg.sv -----
// Shared types for the double-ended record queue: opcodes, record layout, control structs.
`default_nettype none

package dq_pkg;

  // Operation codes carried with each input transaction
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CHECK_ID   = 3'd4
  } op_t;

  localparam int ID_W     = 16;
  localparam int HEALTH_W = 10;
  localparam int POWER_W  = 10;
  localparam int ATTACK_W = 8;

  // One stored record; id sits in the lowest bits
  typedef struct packed {
    logic [ATTACK_W-1:0] attack_cap;
    logic [POWER_W-1:0]  power;
    logic [HEALTH_W-1:0] health;
    logic [ID_W-1:0]     id;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic scan_start;
    logic scan_step;
    logic set_rej;
    logic set_absent;
    logic out_load;
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic match;
    logic scan_last;
    logic out_free;
  } dq_status_t;

endpackage : dq_pkg

`default_nettype wire

// ----- design/dq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : dq_ram

`default_nettype wire

// ----- design/dq_ctrl.sv -----
// Controller state machine for the double-ended record queue.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dq_status_t status,
  output dq_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_FINISH;
        unique case (status.op)
          OP_PUSH_FRONT: begin
            if (status.full) cmd.set_rej = 1'b1;
            else             cmd.push_front = 1'b1;
          end
          OP_PUSH_BACK: begin
            if (status.full) cmd.set_rej = 1'b1;
            else             cmd.push_back = 1'b1;
          end
          OP_POP_FRONT: begin
            if (!status.empty) cmd.pop_front = 1'b1;
          end
          OP_POP_BACK: begin
            if (!status.empty) cmd.pop_back = 1'b1;
          end
          OP_CHECK_ID: begin
            if (status.empty) begin
              cmd.set_absent = 1'b1;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        // read data holds the entry issued last cycle
        if (status.match) begin
          state_next = ST_FINISH;
        end else if (status.scan_last) begin
          cmd.set_absent = 1'b1;
          state_next     = ST_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule : dq_ctrl

`default_nettype wire

// ----- design/dq_dpath.sv -----
// Datapath: pointers, record store, id compare and output register.
`default_nettype none

module dq_dpath
  import dq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire dq_cmd_t                          cmd,
  output dq_status_t                            status,
  input  wire logic [2:0]                       in_op,
  input  wire rec_t                             in_rec,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output rec_t                                  out_rec,
  output logic                                  out_pop_valid,
  output logic                                  out_rej,
  output logic                                  out_absent,
  output logic      [$clog2(DEPTH+1)-1:0]       out_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [IW-1:0] front;
  logic [CW-1:0] count;
  logic [IW-1:0] rd_pos;
  logic [CW-1:0] scan_left;
  rec_t          item;
  op_t           op;
  logic          pop_v, rej, absent;

  logic [SW-1:0] sum, sum_m1;
  logic [IW-1:0] back_wr, back_rd, front_dec, front_inc, rd_inc;
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  rec_t          rdata;

  // Circular position arithmetic
  assign sum       = SW'(front) + SW'(count);
  assign sum_m1    = sum - SW'(1);
  assign back_wr   = (sum >= SW'(DEPTH)) ? IW'(sum - SW'(DEPTH)) : IW'(sum);
  assign back_rd   = (sum_m1 >= SW'(DEPTH)) ? IW'(sum_m1 - SW'(DEPTH)) : IW'(sum_m1);
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign rd_inc    = (rd_pos == IW'(DEPTH - 1)) ? '0 : rd_pos + IW'(1);

  // Store port selection
  assign we    = cmd.push_front | cmd.push_back;
  assign waddr = cmd.push_front ? front_dec : back_wr;
  assign re    = cmd.pop_front | cmd.pop_back | cmd.scan_start | cmd.scan_step;
  always_comb begin
    if (cmd.pop_front || cmd.scan_start) raddr = front;
    else if (cmd.pop_back)               raddr = back_rd;
    else                                 raddr = rd_inc;
  end

  dq_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Front pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      if (cmd.push_front)     front <= front_dec;
      else if (cmd.pop_front) front <= front_inc;
      if (we)                            count <= count + CW'(1);
      else if (cmd.pop_front || cmd.pop_back) count <= count - CW'(1);
    end
  end

  // Latched transaction and scan position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_rec;
      op   <= op_t'(in_op);
    end
    if (cmd.scan_start) begin
      rd_pos    <= front;
      scan_left <= count - CW'(1);
    end else if (cmd.scan_step) begin
      rd_pos    <= rd_inc;
      scan_left <= scan_left - CW'(1);
    end
  end

  // Result flags for the current transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pop_v  <= 1'b0;
      rej    <= 1'b0;
      absent <= 1'b0;
    end else begin
      if (cmd.pop_front || cmd.pop_back) pop_v <= 1'b1;
      if (cmd.set_rej)                   rej <= 1'b1;
      if (cmd.set_absent)                absent <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rec       <= pop_v ? rdata : '0;
      out_pop_valid <= pop_v;
      out_rej       <= rej;
      out_absent    <= absent;
      out_count     <= count;
    end
  end

  // Status back to the controller
  assign status.op        = op;
  assign status.empty     = (count == '0);
  assign status.full      = (count == CW'(DEPTH));
  assign status.match     = (rdata.id == item.id);
  assign status.scan_last = (scan_left == '0);
  assign status.out_free  = !out_valid || out_ready;

endmodule : dq_dpath

`default_nettype wire

// ----- design/double_ended_record_queue.sv -----
// Push, pop and unused codes: accepted in IDLE, executed in EXEC, then loaded into the output
// register from FINISH once it is free; the next input is taken on the return to IDLE.
// Id check: on a non-empty queue, reads one held record a cycle from the store's single read
// port in SCAN until a match or the last entry, then goes on through FINISH like the others.
// Input and output are parted by an output register; a new transaction is taken
// while a result waits. Reset clears front pointer and count; the store is not cleared.
`default_nettype none

module double_ended_record_queue
  import dq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_BITS   = REC_W + 3 + CW,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // unit_id[15:0], unit_health[25:16], unit_power[35:26], unit_attack_cap[43:36]
  input  wire logic [47:0]      s_axis_tdata,
  // opcode[2:0]
  input  wire logic [2:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // out_id, out_health, out_power, out_attack_cap, pop_valid, push_rejected,
  // id_absent, entry_count, zero fill
  output logic [OUT_W-1:0]      m_axis_tdata
);

  dq_cmd_t    cmd;
  dq_status_t status;
  rec_t       in_rec;
  rec_t       out_rec;
  logic       out_pop_valid, out_rej, out_absent;
  logic [CW-1:0] out_count;

  assign in_rec = rec_t'(s_axis_tdata[REC_W-1:0]);

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dq_dpath #(
    .DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_op         (s_axis_tuser),
    .in_rec        (in_rec),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_rec       (out_rec),
    .out_pop_valid (out_pop_valid),
    .out_rej       (out_rej),
    .out_absent    (out_absent),
    .out_count     (out_count)
  );

  // Pack the result transaction, lowest field first
  assign m_axis_tdata = OUT_W'({out_count, out_absent, out_rej, out_pop_valid, out_rec});

  // Count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_count <= CW'(QUEUE_DEPTH)))
    else $error("entry count beyond depth");

  // At most one outcome flag per result
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0({out_pop_valid, out_rej, out_absent}))
    else $error("more than one outcome flag set");

  // One transaction in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a transaction is in work");

  // A full queue never takes a write
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !(cmd.push_front || cmd.push_back))
    else $error("write while full");

endmodule : double_ended_record_queue

`default_nettype wire

// ----- dv/deque_checker.sv -----
// Scoreboard for the record deque: mirrors the queue, predicts each result and compares it.
module deque_checker
  import dq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int OUT_W = 56
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [47:0]      in_data,
  input  logic [2:0]       in_op,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [OUT_W-1:0] out_data,
  output int               errors,
  output int               waiting,
  output int               results,
  output int               full_rejects,
  output int               empty_pops,
  output int               id_hits,
  output int               peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = $clog2(DEPTH + 1);

  // Result layout, lowest bits first: record, then the three flags, then the count
  typedef struct packed {
    logic [CW-1:0] count;
    logic          absent;
    logic          rejected;
    logic          popped;
    rec_t          rec;
  } outcome_t;

  // Mirror of the deque
  rec_t        slots [DEPTH];
  int unsigned head;
  int unsigned fill;

  outcome_t    pending_q [$];

  // Apply one operation to the mirror and return the result it should give
  function automatic outcome_t apply_op(logic [2:0] code, rec_t r);
    outcome_t o;
    o = '0;
    case (code)
      OP_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          o.rejected = 1'b1;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          slots[head] = r;
          fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          o.rejected = 1'b1;
        end else begin
          slots[(head + fill) % DEPTH] = r;
          fill++;
        end
      end
      OP_POP_FRONT: begin
        if (fill != 0) begin
          o.rec = slots[head];
          o.popped = 1'b1;
          head = (head + 1) % DEPTH;
          fill--;
        end
      end
      OP_POP_BACK: begin
        if (fill != 0) begin
          o.rec = slots[(head + fill - 1) % DEPTH];
          o.popped = 1'b1;
          fill--;
        end
      end
      OP_CHECK_ID: begin
        o.absent = 1'b1;
        for (int unsigned k = 0; k < fill; k++) begin
          if (slots[(head + k) % DEPTH].id == r.id) o.absent = 1'b0;
        end
      end
      default: ;  // unused codes leave the deque alone
    endcase
    o.count = fill[CW-1:0];
    return o;
  endfunction

  // Report one field mismatch; returns 1 when the field differs
  function automatic int cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // Compare outgoing transactions first, then record the incoming one
  always @(posedge clk) begin
    outcome_t exp_o;
    outcome_t act_o;
    logic [2:0] code;
    int bad;
    bad = 0;
    if (rst) begin
      head = 0;
      fill = 0;
      pending_q.delete();
      errors <= 0;
      waiting <= 0;
      results <= 0;
      full_rejects <= 0;
      empty_pops <= 0;
      id_hits <= 0;
      peak_fill <= 0;
    end else begin
      if (out_valid && out_ready) begin
        act_o = out_data[$bits(outcome_t)-1:0];
        results <= results + 1;
        if (pending_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual 0x%0h", $time, out_data);
          bad++;
        end else begin
          exp_o = pending_q.pop_front();
          bad += cmp_field("out_id", 32'(exp_o.rec.id), 32'(act_o.rec.id));
          bad += cmp_field("out_health", 32'(exp_o.rec.health), 32'(act_o.rec.health));
          bad += cmp_field("out_power", 32'(exp_o.rec.power), 32'(act_o.rec.power));
          bad += cmp_field("out_attack_cap", 32'(exp_o.rec.attack_cap),
                           32'(act_o.rec.attack_cap));
          bad += cmp_field("pop_valid", 32'(exp_o.popped), 32'(act_o.popped));
          bad += cmp_field("push_rejected", 32'(exp_o.rejected), 32'(act_o.rejected));
          bad += cmp_field("id_absent", 32'(exp_o.absent), 32'(act_o.absent));
          bad += cmp_field("entry_count", 32'(exp_o.count), 32'(act_o.count));
        end
      end
      if (in_valid && in_ready) begin
        code = in_op;
        exp_o = apply_op(code, rec_t'(in_data[$bits(rec_t)-1:0]));
        pending_q.push_back(exp_o);
        if (exp_o.rejected) full_rejects <= full_rejects + 1;
        if ((code == OP_POP_FRONT || code == OP_POP_BACK) && !exp_o.popped)
          empty_pops <= empty_pops + 1;
        if (code == OP_CHECK_ID && !exp_o.absent) id_hits <= id_hits + 1;
        if (fill > peak_fill) peak_fill <= fill;
      end
      errors <= errors + bad;
      waiting <= pending_q.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the record deque: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
  import dq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 64;
  localparam int OUT_W      = ((REC_W + 3 + $clog2(DEPTH + 1) + 7) / 8) * 8;
  localparam int ITEM_GOAL  = 1400;
  localparam int CALM_TAIL  = 150;
  localparam int CYCLE_CAP  = 1000000;

  // Traffic mixes for the random part
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_SEARCH = 2;
  localparam int MIX_ANY    = 3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [47:0]      s_axis_tdata = '0;
  logic [2:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int  errors, waiting, results, full_rejects, empty_pops, id_hits, peak_fill;
  int  cycles = 0;
  int  sent = 0;
  bit  idle_on = 1'b1;

  always #6 clk = ~clk;

  double_ended_record_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  deque_checker #(.DEPTH(DEPTH), .OUT_W(OUT_W)) chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_data      (s_axis_tdata),
    .in_op        (s_axis_tuser),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_data     (m_axis_tdata),
    .errors       (errors),
    .waiting      (waiting),
    .results      (results),
    .full_rejects (full_rejects),
    .empty_pops   (empty_pops),
    .id_hits      (id_hits),
    .peak_fill    (peak_fill)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stall bursts while idling is enabled
  initial begin
    int stall_left;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one transaction, with an optional gap first; returns just after a falling edge
  task automatic send(input logic [2:0] code, input rec_t r);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, r};
    s_axis_tuser  <= code;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (code <= OP_CHECK_ID) sent++;
  endtask

  // Hold off new input until every outstanding result has come back
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  // Ids mostly from a small pool so that checks and duplicates hit
  function automatic rec_t rand_rec();
    rec_t r;
    r.id         = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                 : 16'($urandom_range(0, 23));
    r.health     = 10'($urandom_range(0, 1023));
    r.power      = 10'($urandom_range(0, 1023));
    r.attack_cap = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic logic [2:0] pick_op(int mix);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 3'($urandom_range(5, 7));  // unused codes as noise
    case (mix)
      MIX_GROW:
        if (roll < 70) return 3'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK));
        else if (roll < 85) return OP_CHECK_ID;
        else return 3'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
      MIX_SHRINK:
        if (roll < 70) return 3'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
        else if (roll < 85) return OP_CHECK_ID;
        else return 3'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK));
      MIX_SEARCH:
        if (roll < 60) return OP_CHECK_ID;
        else return 3'($urandom_range(OP_PUSH_FRONT, OP_POP_BACK));
      default:
        return 3'($urandom_range(OP_PUSH_FRONT, OP_CHECK_ID));
    endcase
  endfunction

  initial begin
    rec_t top_rec, zero_rec, mid_rec, dup_rec, key;
    int   mix, block_len;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    top_rec  = '{attack_cap: 8'hFF, power: 10'h3FF, health: 10'h3FF, id: 16'hFFFF};
    zero_rec = '0;
    mid_rec  = '{attack_cap: 8'h5A, power: 10'h2AA, health: 10'h155, id: 16'h00A5};
    dup_rec  = '{attack_cap: 8'hA5, power: 10'h155, health: 10'h2AA, id: 16'hFFFF};

    // Directed: empty-queue cases, field extremes, duplicates, unused codes
    key = '0;
    send(OP_CHECK_ID, key);
    send(OP_POP_FRONT, top_rec);
    send(OP_POP_BACK, top_rec);
    send(OP_PUSH_FRONT, top_rec);
    send(OP_PUSH_BACK, zero_rec);
    send(OP_PUSH_FRONT, mid_rec);
    send(OP_PUSH_BACK, dup_rec);
    key.id = 16'hFFFF;
    send(OP_CHECK_ID, key);
    key.id = 16'h0000;
    send(OP_CHECK_ID, key);
    key.id = 16'h1234;
    send(OP_CHECK_ID, key);
    send(3'd5, top_rec);
    send(3'd6, mid_rec);
    send(3'd7, dup_rec);
    send(OP_POP_BACK, zero_rec);
    send(OP_POP_FRONT, zero_rec);
    send(OP_POP_FRONT, zero_rec);
    key.id = 16'hFFFF;
    send(OP_CHECK_ID, key);
    send(OP_POP_BACK, zero_rec);
    send(OP_POP_BACK, zero_rec);
    key.id = 16'h0000;
    send(OP_CHECK_ID, key);
    drain_wait();

    // Fill past the bound, then empty past zero
    for (int i = 0; i < DEPTH + 3; i++)
      send(3'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK)), rand_rec());
    for (int i = 0; i < 8; i++) send(OP_CHECK_ID, rand_rec());
    for (int i = 0; i < DEPTH + 3; i++)
      send(3'($urandom_range(OP_POP_FRONT, OP_POP_BACK)), rand_rec());
    drain_wait();

    // Random blocks of mixed traffic
    while (sent < ITEM_GOAL) begin
      mix = $urandom_range(MIX_GROW, MIX_ANY);
      block_len = $urandom_range(20, 90);
      if ($urandom_range(0, 3) == 0) drain_wait();
      for (int i = 0; i < block_len && sent < ITEM_GOAL; i++) begin
        if (sent >= ITEM_GOAL - CALM_TAIL) idle_on = 1'b0;
        send(pick_op(mix), rand_rec());
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let outstanding results arrive, then allow for a full id scan
    while (waiting != 0) @(negedge clk);
    repeat (DEPTH + 16) @(negedge clk);

    $display("Checked %0d results; %0d pushes hit a full queue, %0d pops hit an empty one.",
             results, full_rejects, empty_pops);
    $display("%0d id searches found a match; occupancy peaked at %0d of %0d.",
             id_hits, peak_fill, DEPTH);
    if (errors == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
